// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed: label");

`endif

// File: hw/rtl/iair_pkg.sv
// Package with the command, status and state codes and the reset capacity limit of the indexed array.
`default_nettype none

package iair_pkg;

   localparam logic [2:0] CMD_PUSH   = 3'd0;
   localparam logic [2:0] CMD_POP    = 3'd1;
   localparam logic [2:0] CMD_INSERT = 3'd2;
   localparam logic [2:0] CMD_REMOVE = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_EMPTY  = 2'd2;
   localparam logic [1:0] STAT_BADIDX = 2'd3;

   localparam logic [5:0] CAP_RESET = 6'd32;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SHIFT,
      SEQ_READ
   } state_type;

endpackage

`default_nettype wire

// File: hw/rtl/indexed_array_insert_remove.sv
// Top level of the indexed array: a word memory with push, pop, insert, remove and read.
// Push, pop, no-op, every refused command, an insert at the end and a remove of the last word
// finish at acceptance and strobe their result in the next cycle; a read goes through SEQ_READ
// first, and an insert or remove that moves stored words goes through SEQ_SHIFT, one word per
// cycle through the single ports. Busy is low in the strobe cycle, so the next command can be
// accepted then but not before. Synchronous reset empties the array and sets the limit to 32.
`default_nettype none

module indexed_array_insert_remove #(
   parameter int DEPTH      = 32,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Command channel.
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_command,
   input  wire logic [4:0]         req_position,
   input  wire logic signed [31:0] req_value,
   // Result channel: one strobe cycle per result, no back pressure.
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_read_value,
   output logic [5:0]              rsp_element_count,
   output logic [1:0]              rsp_status,
   // Capacity limit register.
   input  wire logic               csr_write_enable,
   input  wire logic [5:0]         csr_write_data
);

   import iair_pkg::*;

   localparam int AW = $clog2(DEPTH);
   // Index arithmetic runs at the wider of the address and count widths.
   localparam int IW = (AW > 6) ? AW : 6;

   // Element memory: one write port and one registered read port.
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] mem_rdata_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic                  mem_re;
   logic [AW-1:0]         mem_raddr;

   // Sequencer and shift bookkeeping.
   state_type             state_ff, state_in;
   logic [5:0]            count_ff, count_in;
   logic [5:0]            cap_ff, cap_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [AW-1:0]         end_ff, end_in;
   logic                  dir_up_ff, dir_up_in;
   logic                  rd_active_ff, rd_active_in;
   logic                  wr_pend_ff, wr_pend_in;
   logic [AW-1:0]         wr_addr_ff, wr_addr_in;
   logic [AW-1:0]         fin_addr_ff, fin_addr_in;
   logic [DATA_WIDTH-1:0] fin_data_ff, fin_data_in;

   // Result registers.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]    rsp_read_value_ff, rsp_read_value_in;
   logic [5:0]            rsp_count_ff, rsp_count_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   // Decoded view of the incoming command.
   logic                  accept;
   logic                  full;
   logic [5:0]            pos6;
   logic [5:0]            last6;
   logic [DATA_WIDTH-1:0] word_in;

   // Turns a count-sized index into a memory address. Every index handed in here is known
   // to lie below DEPTH, so dropping the upper bits loses nothing.
   function automatic logic [AW-1:0] to_addr(input logic [5:0] idx);
      logic [IW-1:0] wide;
      wide = IW'(idx);
      return wide[AW-1:0];
   endfunction

   // Sign-extends a stored word to the 32-bit result. A word wider than 32 bits only ever
   // holds a zero-extended 32-bit value, so its low 32 bits are taken as they are.
   function automatic logic [31:0] widen(input logic [DATA_WIDTH-1:0] word);
      logic [63:0] pad;
      logic [63:0] wide;
      pad = 64'(word);
      for (int b = 0; b < 64; b++) begin
         if (b < DATA_WIDTH) begin
            wide[b] = pad[b];
         end else begin
            wide[b] = (DATA_WIDTH <= 32) ? pad[DATA_WIDTH-1] : 1'b0;
         end
      end
      return wide[31:0];
   endfunction

   assign accept  = start && !busy;
   assign pos6    = {1'b0, req_position};
   assign last6   = count_ff - 6'd1;
   // The limit saturates at DEPTH, and a limit of zero admits nothing.
   assign full    = (count_ff >= cap_ff) || (32'(count_ff) >= DEPTH);
   assign word_in = DATA_WIDTH'({32'b0, req_value});

   assign busy              = (state_ff != SEQ_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_value    = rsp_read_value_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   // The next state and every memory access are decided here.
   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      cap_in            = cap_ff;
      ptr_in            = ptr_ff;
      end_in            = end_ff;
      dir_up_in         = dir_up_ff;
      rd_active_in      = rd_active_ff;
      wr_pend_in        = wr_pend_ff;
      wr_addr_in        = wr_addr_ff;
      fin_addr_in       = fin_addr_ff;
      fin_data_in       = fin_data_ff;
      rsp_valid_in      = 1'b0;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_status_in     = rsp_status_ff;
      mem_we            = 1'b0;
      mem_waddr         = '0;
      mem_wdata         = '0;
      mem_re            = 1'b0;
      mem_raddr         = '0;

      if (csr_write_enable) begin
         cap_in = csr_write_data;
      end

      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               // Most commands finish in this cycle; the strobe follows at the next edge.
               // The count is final at acceptance, since nothing else looks at it while
               // a shift is under way.
               rsp_read_value_in = '0;
               rsp_status_in     = STAT_OK;
               rsp_valid_in      = 1'b1;
               case (req_command)
                  CMD_PUSH: begin
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = to_addr(count_ff);
                        mem_wdata = word_in;
                        count_in  = count_ff + 6'd1;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == 6'd0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = to_addr(last6);
                        mem_wdata = '0;
                        count_in  = last6;
                     end
                  end
                  CMD_INSERT: begin
                     // The full check takes precedence over the index check.
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else if (pos6 > count_ff) begin
                        rsp_status_in = STAT_BADIDX;
                     end else if (pos6 == count_ff) begin
                        // Inserting at the end is an append: nothing moves.
                        mem_we    = 1'b1;
                        mem_waddr = to_addr(count_ff);
                        mem_wdata = word_in;
                        count_in  = count_ff + 6'd1;
                     end else begin
                        // Move words up, starting from the last live one.
                        count_in     = count_ff + 6'd1;
                        ptr_in       = to_addr(last6);
                        end_in       = to_addr(pos6);
                        dir_up_in    = 1'b0;
                        rd_active_in = 1'b1;
                        wr_pend_in   = 1'b0;
                        fin_addr_in  = to_addr(pos6);
                        fin_data_in  = word_in;
                        rsp_valid_in = 1'b0;
                        state_in     = SEQ_SHIFT;
                     end
                  end
                  CMD_REMOVE: begin
                     if (count_ff == 6'd0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else if (pos6 >= count_ff) begin
                        rsp_status_in = STAT_BADIDX;
                     end else if (pos6 == last6) begin
                        // Removing the last word only clears its slot.
                        mem_we    = 1'b1;
                        mem_waddr = to_addr(last6);
                        mem_wdata = '0;
                        count_in  = last6;
                     end else begin
                        // Move words down from just past the index; the vacated last slot
                        // is cleared at the end.
                        count_in     = last6;
                        ptr_in       = to_addr(pos6 + 6'd1);
                        end_in       = to_addr(last6);
                        dir_up_in    = 1'b1;
                        rd_active_in = 1'b1;
                        wr_pend_in   = 1'b0;
                        fin_addr_in  = to_addr(last6);
                        fin_data_in  = '0;
                        rsp_valid_in = 1'b0;
                        state_in     = SEQ_SHIFT;
                     end
                  end
                  CMD_READ: begin
                     if (pos6 >= count_ff) begin
                        rsp_status_in = STAT_BADIDX;
                     end else begin
                        mem_re       = 1'b1;
                        mem_raddr    = to_addr(pos6);
                        rsp_valid_in = 1'b0;
                        state_in     = SEQ_READ;
                     end
                  end
                  default: begin
                     // Unused command codes do nothing and report ok.
                  end
               endcase
               rsp_count_in = count_in;
            end
         end

         SEQ_SHIFT: begin
            // Reads run ahead of writes. The write address always lies on the side
            // already read, so a write never lands on a word that is still to be read and
            // no forwarding is needed.
            if (wr_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_addr_ff;
               mem_wdata = mem_rdata_ff;
            end
            if (rd_active_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = ptr_ff;
               wr_pend_in = 1'b1;
               if (dir_up_ff) begin
                  wr_addr_in = AW'(ptr_ff - 1'b1);
                  ptr_in     = AW'(ptr_ff + 1'b1);
               end else begin
                  wr_addr_in = AW'(ptr_ff + 1'b1);
                  ptr_in     = AW'(ptr_ff - 1'b1);
               end
               if (ptr_ff == end_ff) begin
                  rd_active_in = 1'b0;
               end
            end else begin
               wr_pend_in = 1'b0;
            end
            if (!rd_active_ff && !wr_pend_ff) begin
               // Final write: the new word for insert, a zero for remove.
               mem_we       = 1'b1;
               mem_waddr    = fin_addr_ff;
               mem_wdata    = fin_data_ff;
               rsp_valid_in = 1'b1;
               state_in     = SEQ_IDLE;
            end
         end

         SEQ_READ: begin
            rsp_read_value_in = signed'(widen(mem_rdata_ff));
            rsp_valid_in      = 1'b1;
            state_in          = SEQ_IDLE;
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rd_active_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rd_active_ff <= rd_active_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      ptr_ff            <= ptr_in;
      end_ff            <= end_in;
      dir_up_ff         <= dir_up_in;
      wr_addr_ff        <= wr_addr_in;
      fin_addr_ff       <= fin_addr_in;
      fin_data_ff       <= fin_data_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_status_ff     <= rsp_status_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/iair_checker.sv
// Port-level checker for the indexed array, with the bind that attaches it.
`default_nettype none

`include "assert_macros.svh"

module iair_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire logic signed [31:0] rsp_read_value,
   input wire logic [5:0]         rsp_element_count,
   input wire logic [1:0]         rsp_status
);

   import iair_pkg::*;

   `ASSERT_CLK(a_accept_progress, clock, reset, (start && !busy) |=> (busy || rsp_valid))
   `ASSERT_CLK(a_result_when_idle, clock, reset, rsp_valid |-> !busy)
   `ASSERT_CLK(a_refused_no_data, clock, reset, (rsp_valid && rsp_status != STAT_OK) |-> (rsp_read_value == 32'sd0))
   `ASSERT_CLK(a_empty_means_zero, clock, reset, (rsp_valid && rsp_status == STAT_EMPTY) |-> (rsp_element_count == 6'd0))
   `ASSERT_CLK_ALWAYS(a_reset_quiet, clock, reset |=> (!rsp_valid && !busy))

endmodule

bind indexed_array_insert_remove iair_checker u_iair_checker (.*);

`default_nettype wire
